[rtl/assert_macros.svh]
// assertion macros used by the checker file
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked property with active-low reset disable
`define MPPP_ASSERT(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

// a stalled word stays valid and keeps the given signal steady
`define MPPP_ASSERT_HOLD(label, clk, rstn, vld, rdy, sig, msg) \
    `MPPP_ASSERT(label, clk, rstn, (vld) && !(rdy) |=> (vld) && $stable(sig), msg)

`endif

[rtl/mppp_pkg.sv]
// shared types, constants and pin tables of the position pid block
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package mppp_pkg;

    localparam int CHANNELS_DEF    = 6;
    localparam int QUEUE_DEPTH_DEF = 2;

    localparam logic signed [15:0] GAIN_P_RST = 16'sd256;
    localparam logic signed [15:0] GAIN_I_RST = 16'sd0;
    localparam logic signed [15:0] GAIN_D_RST = 16'sd0;
    localparam logic [13:0]        LIMIT_RST  = 14'd1000;

    localparam logic signed [25:0] SPEED_MAX = 26'sd100;
    localparam logic signed [25:0] SPEED_MIN = -26'sd100;

    typedef enum logic {
        OP_SET    = 1'b0,
        OP_UPDATE = 1'b1
    } op_e_t;

    typedef enum logic [1:0] {
        REG_GAIN_P = 2'd0,
        REG_GAIN_I = 2'd1,
        REG_GAIN_D = 2'd2,
        REG_LIMIT  = 2'd3
    } reg_idx_t;

    typedef struct packed {
        op_e_t       op;
        logic [2:0]  ch;
        logic [15:0] value;
    } q_item_t;

    typedef struct packed {
        logic [15:0] gain_p;
        logic [15:0] gain_i;
        logic [15:0] gain_d;
        logic [13:0] limit;
    } cfg_t;

    // pin driven by positive speed
    function automatic logic [3:0] pos_pin(input logic [2:0] ch);
        logic [3:0] pin;
        case (ch)
            3'd0:    pin = 4'd8;
            3'd1:    pin = 4'd2;
            3'd2:    pin = 4'd10;
            3'd3:    pin = 4'd0;
            3'd4:    pin = 4'd4;
            3'd5:    pin = 4'd7;
            default: pin = 4'd12;
        endcase
        return pin;
    endfunction

    // pin driven by negative speed
    function automatic logic [3:0] neg_pin(input logic [2:0] ch);
        logic [3:0] pin;
        case (ch)
            3'd0:    pin = 4'd9;
            3'd1:    pin = 4'd3;
            3'd2:    pin = 4'd11;
            3'd3:    pin = 4'd1;
            3'd4:    pin = 4'd5;
            3'd5:    pin = 4'd6;
            default: pin = 4'd13;
        endcase
        return pin;
    endfunction

    function automatic logic [10:0] duty_base(input logic [2:0] ch);
        logic [10:0] base;
        case (ch)
            3'd0, 3'd5: base = 11'd500;
            default:    base = 11'd1000;
        endcase
        return base;
    endfunction

    // span / 100, exact for both spans in use
    function automatic logic [4:0] duty_pct(input logic [2:0] ch);
        logic [4:0] pct;
        case (ch)
            3'd0, 3'd5: pct = 5'd25;
            default:    pct = 5'd30;
        endcase
        return pct;
    endfunction

endpackage

`default_nettype wire

[rtl/mppp_front.sv]
// front end: accepts input words, drops bad channels, tags the operation
// depends on mppp_pkg
`timescale 1ns / 1ps
`default_nettype none

module mppp_front import mppp_pkg::*; #(
    parameter int CHANNELS = CHANNELS_DEF
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic        s_kind,
    input  wire logic [2:0]  s_channel,
    input  wire logic [15:0] s_value,
    output logic             q_valid,
    input  wire logic        q_ready,
    output q_item_t          q_item
);

    localparam logic [4:0] CH_LIMIT = 5'(CHANNELS);

    logic    f_valid_reg, f_valid_next;
    q_item_t f_item_reg, f_item_next;
    logic    ch_ok;

    assign s_ready = !f_valid_reg || q_ready;
    assign ch_ok   = {2'b00, s_channel} < CH_LIMIT;

    always_comb begin
        f_valid_next = f_valid_reg;
        f_item_next  = f_item_reg;
        if (s_ready) begin
            // out-of-range channels are consumed and dropped here
            f_valid_next     = s_valid && ch_ok;
            f_item_next.op   = s_kind ? OP_UPDATE : OP_SET;
            f_item_next.ch   = s_channel;
            f_item_next.value = s_value;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            f_valid_reg <= 1'b0;
        end else begin
            f_valid_reg <= f_valid_next;
        end
        f_item_reg <= f_item_next;
    end

    assign q_valid = f_valid_reg;
    assign q_item  = f_item_reg;

endmodule

`default_nettype wire

[rtl/mppp_fifo.sv]
// short queue between front and back end
// depends on mppp_pkg
`timescale 1ns / 1ps
`default_nettype none

module mppp_fifo import mppp_pkg::*; #(
    parameter int DEPTH = QUEUE_DEPTH_DEF
) (
    input  wire logic    aclk,
    input  wire logic    aresetn,
    input  wire logic    wr_valid,
    output logic         wr_ready,
    input  wire q_item_t wr_item,
    output logic         rd_valid,
    input  wire logic    rd_en,
    output q_item_t      rd_item
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    q_item_t          mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             do_wr, do_rd;

    assign wr_ready = cnt_reg != CNT_FULL;
    assign rd_valid = cnt_reg != '0;
    assign rd_item  = mem_reg[rd_ptr_reg];
    assign do_wr    = wr_valid && wr_ready;
    assign do_rd    = rd_en && rd_valid;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_wr) begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_rd) begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_wr && !do_rd) begin
            cnt_next = cnt_reg + 1'b1;
        end else if (do_rd && !do_wr) begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
        if (do_wr) begin
            mem_reg[wr_ptr_reg] <= wr_item;
        end
    end

endmodule

`default_nettype wire

[rtl/mppp_back.sv]
// back end: per-channel state update, pid pipeline, pwm pin mapping, output register
// depends on mppp_pkg
`timescale 1ns / 1ps
`default_nettype none

module mppp_back import mppp_pkg::*; #(
    parameter int CHANNELS = CHANNELS_DEF
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire cfg_t        cfg,
    input  wire logic        q_valid,
    output logic             q_pop,
    input  wire q_item_t     q_item,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [2:0]       m_out_channel,
    output logic [7:0]       m_speed,
    output logic [3:0]       m_drive_pin,
    output logic [11:0]      m_drive_duty,
    output logic [3:0]       m_idle_pin,
    output logic             m_reached_target
);

    localparam int IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

    // per-channel state
    logic [15:0]         target_reg [CHANNELS];
    logic [15:0]         sum_reg    [CHANNELS];
    logic [15:0]         last_reg   [CHANNELS];
    logic [CHANNELS-1:0] active_reg;

    logic             adv;
    logic [IDX_W-1:0] idx;
    logic             is_upd;
    logic             upd_next;
    logic [15:0]      err_next, deriv_next, sum_next;
    logic signed [16:0] sum_wide, lim_pos, lim_neg;

    // stage 1: error terms
    logic        s1_valid_reg;
    logic [2:0]  s1_ch_reg;
    logic [15:0] s1_err_reg, s1_sum_reg, s1_deriv_reg;
    logic        s1_reached_reg;

    // stage 2: products
    logic        s2_valid_reg;
    logic [2:0]  s2_ch_reg;
    logic        s2_reached_reg;
    logic signed [31:0] s2_p_reg, s2_i_reg, s2_d_reg;
    logic signed [31:0] p_next, i_next, d_next;

    // stage 3: sum
    logic        s3_valid_reg;
    logic [2:0]  s3_ch_reg;
    logic        s3_reached_reg;
    logic signed [33:0] s3_acc_reg, acc_next;

    // stage 4: speed
    logic        s4_valid_reg;
    logic [2:0]  s4_ch_reg;
    logic        s4_reached_reg;
    logic signed [7:0]  s4_speed_reg, speed_next;
    logic signed [33:0] acc_adj;
    logic signed [25:0] quot;

    // output register
    logic        m_valid_reg;
    logic [2:0]  m_ch_reg;
    logic [7:0]  m_speed_reg;
    logic [3:0]  m_drive_pin_reg, m_idle_pin_reg;
    logic [11:0] m_duty_reg;
    logic        m_reached_reg;
    logic [6:0]  mag;
    logic [3:0]  drive_pin_next, idle_pin_next;
    logic [11:0] duty_next;

    assign adv   = !m_valid_reg || m_ready;
    assign q_pop = adv && q_valid;
    assign idx   = IDX_W'(q_item.ch);
    assign is_upd = q_item.op == OP_UPDATE;
    assign upd_next = q_pop && is_upd && active_reg[idx];

    always_comb begin
        err_next   = target_reg[idx] - q_item.value;
        deriv_next = q_item.value - last_reg[idx];
        sum_wide   = $signed({sum_reg[idx][15], sum_reg[idx]})
                   + $signed({err_next[15], err_next});
        lim_pos    = $signed({3'b000, cfg.limit});
        lim_neg    = -lim_pos;
        // anti-windup clamp
        if (sum_wide > lim_pos) begin
            sum_next = lim_pos[15:0];
        end else if (sum_wide < lim_neg) begin
            sum_next = lim_neg[15:0];
        end else begin
            sum_next = sum_wide[15:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            active_reg <= '0;
            for (int i = 0; i < CHANNELS; i++) begin
                sum_reg[i]  <= '0;
                last_reg[i] <= '0;
            end
        end else if (q_pop) begin
            if (!is_upd) begin
                target_reg[idx] <= q_item.value;
                sum_reg[idx]    <= '0;
                active_reg[idx] <= 1'b1;
            end else if (active_reg[idx]) begin
                sum_reg[idx]  <= sum_next;
                last_reg[idx] <= q_item.value;
                if (err_next == '0) begin
                    active_reg[idx] <= 1'b0;
                end
            end
        end
    end

    assign p_next = 32'($signed(cfg.gain_p)) * 32'($signed(s1_err_reg));
    assign i_next = 32'($signed(cfg.gain_i)) * 32'($signed(s1_sum_reg));
    assign d_next = 32'($signed(cfg.gain_d)) * 32'($signed(s1_deriv_reg));

    assign acc_next = 34'(s2_p_reg) + 34'(s2_i_reg) - 34'(s2_d_reg);

    always_comb begin
        // divide by 256 truncating toward zero
        acc_adj = s3_acc_reg[33] ? s3_acc_reg + 34'sd255 : s3_acc_reg;
        quot    = $signed(acc_adj[33:8]);
        if (s3_reached_reg) begin
            speed_next = '0;
        end else if (quot > SPEED_MAX) begin
            speed_next = SPEED_MAX[7:0];
        end else if (quot < SPEED_MIN) begin
            speed_next = SPEED_MIN[7:0];
        end else begin
            speed_next = quot[7:0];
        end
    end

    always_comb begin
        mag = s4_speed_reg[7] ? 7'(-s4_speed_reg) : s4_speed_reg[6:0];
        if (s4_speed_reg[7]) begin
            drive_pin_next = neg_pin(s4_ch_reg);
            idle_pin_next  = pos_pin(s4_ch_reg);
        end else begin
            drive_pin_next = pos_pin(s4_ch_reg);
            idle_pin_next  = neg_pin(s4_ch_reg);
        end
        if (s4_speed_reg == '0) begin
            duty_next = '0;
        end else begin
            duty_next = 12'({5'd0, mag} * {7'd0, duty_pct(s4_ch_reg)})
                      + {1'b0, duty_base(s4_ch_reg)};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            s4_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else if (adv) begin
            s1_valid_reg <= upd_next;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
            s4_valid_reg <= s3_valid_reg;
            m_valid_reg  <= s4_valid_reg;
        end
        if (adv) begin
            s1_ch_reg       <= q_item.ch;
            s1_err_reg      <= err_next;
            s1_sum_reg      <= sum_next;
            s1_deriv_reg    <= deriv_next;
            s1_reached_reg  <= err_next == '0;
            s2_ch_reg       <= s1_ch_reg;
            s2_reached_reg  <= s1_reached_reg;
            s2_p_reg        <= p_next;
            s2_i_reg        <= i_next;
            s2_d_reg        <= d_next;
            s3_ch_reg       <= s2_ch_reg;
            s3_reached_reg  <= s2_reached_reg;
            s3_acc_reg      <= acc_next;
            s4_ch_reg       <= s3_ch_reg;
            s4_reached_reg  <= s3_reached_reg;
            s4_speed_reg    <= speed_next;
            m_ch_reg        <= s4_ch_reg;
            m_speed_reg     <= s4_speed_reg;
            m_drive_pin_reg <= drive_pin_next;
            m_idle_pin_reg  <= idle_pin_next;
            m_duty_reg      <= duty_next;
            m_reached_reg   <= s4_reached_reg;
        end
    end

    assign m_valid          = m_valid_reg;
    assign m_out_channel    = m_ch_reg;
    assign m_speed          = m_speed_reg;
    assign m_drive_pin      = m_drive_pin_reg;
    assign m_drive_duty     = m_duty_reg;
    assign m_idle_pin       = m_idle_pin_reg;
    assign m_reached_target = m_reached_reg;

endmodule

`default_nettype wire

[rtl/multichannel_position_pid_pwm_top.sv]
// channel    | handshake                 | payload
// s_ (in)    | s_valid / s_ready         | s_kind, s_channel, s_value
// m_ (out)   | m_valid / m_ready         | m_out_channel, m_speed, m_drive_pin,
//            |                           | m_drive_duty, m_idle_pin, m_reached_target
// apb (cfg)  | psel, penable, pwrite     | paddr, pwdata, prdata, pready
//
// one word per cycle sustained while m_ready does not stall; an update to an active channel
// reaches m_ through the front register, queue, state stage, multiply, add, scale and output register
// the per-channel state read-modify-write sits in one stage, so same-channel words
// may follow each other on consecutive cycles
// reset is synchronous and active low; all channels come up inactive
// a stall on m_ready freezes the back end; the two-entry queue and front register absorb s_
// top level of the multichannel position pid with pwm pin mapping
// depends on mppp_pkg, mppp_front, mppp_fifo, mppp_back
`timescale 1ns / 1ps
`default_nettype none

module multichannel_position_pid_pwm_top import mppp_pkg::*; #(
    parameter int CHANNELS    = CHANNELS_DEF,
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic        s_kind,
    input  wire logic [2:0]  s_channel,
    input  wire logic [15:0] s_value,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [2:0]       m_out_channel,
    output logic [7:0]       m_speed,
    output logic [3:0]       m_drive_pin,
    output logic [11:0]      m_drive_duty,
    output logic [3:0]       m_idle_pin,
    output logic             m_reached_target,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [3:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    cfg_t     cfg_reg;
    reg_idx_t reg_sel;
    logic     cfg_wr;

    logic    f_valid, f_ready;
    q_item_t f_item;
    logic    q_valid, q_pop;
    q_item_t q_item;

    assign pready  = 1'b1;
    assign reg_sel = reg_idx_t'(paddr[3:2]);
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.gain_p <= GAIN_P_RST;
            cfg_reg.gain_i <= GAIN_I_RST;
            cfg_reg.gain_d <= GAIN_D_RST;
            cfg_reg.limit  <= LIMIT_RST;
        end else if (cfg_wr) begin
            case (reg_sel)
                REG_GAIN_P: cfg_reg.gain_p <= pwdata[15:0];
                REG_GAIN_I: cfg_reg.gain_i <= pwdata[15:0];
                REG_GAIN_D: cfg_reg.gain_d <= pwdata[15:0];
                REG_LIMIT:  cfg_reg.limit  <= pwdata[13:0];
                default:    ;
            endcase
        end
    end

    always_comb begin
        case (reg_sel)
            REG_GAIN_P: prdata = {{16{cfg_reg.gain_p[15]}}, cfg_reg.gain_p};
            REG_GAIN_I: prdata = {{16{cfg_reg.gain_i[15]}}, cfg_reg.gain_i};
            REG_GAIN_D: prdata = {{16{cfg_reg.gain_d[15]}}, cfg_reg.gain_d};
            REG_LIMIT:  prdata = {18'd0, cfg_reg.limit};
            default:    prdata = '0;
        endcase
    end

    mppp_front #(
        .CHANNELS (CHANNELS)
    ) u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_kind    (s_kind),
        .s_channel (s_channel),
        .s_value   (s_value),
        .q_valid   (f_valid),
        .q_ready   (f_ready),
        .q_item    (f_item)
    );

    mppp_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr_valid (f_valid),
        .wr_ready (f_ready),
        .wr_item  (f_item),
        .rd_valid (q_valid),
        .rd_en    (q_pop),
        .rd_item  (q_item)
    );

    mppp_back #(
        .CHANNELS (CHANNELS)
    ) u_back (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cfg              (cfg_reg),
        .q_valid          (q_valid),
        .q_pop            (q_pop),
        .q_item           (q_item),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_out_channel    (m_out_channel),
        .m_speed          (m_speed),
        .m_drive_pin      (m_drive_pin),
        .m_drive_duty     (m_drive_duty),
        .m_idle_pin       (m_idle_pin),
        .m_reached_target (m_reached_target)
    );

endmodule

`default_nettype wire

[rtl/mppp_checker.sv]
// port-level checks on the result channel of the position pid top level
// depends on assert_macros.svh; bound to multichannel_position_pid_pwm_top
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module mppp_checker (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        m_valid,
    input wire logic        m_ready,
    input wire logic [7:0]  m_speed,
    input wire logic [3:0]  m_drive_pin,
    input wire logic [11:0] m_drive_duty,
    input wire logic [3:0]  m_idle_pin,
    input wire logic        m_reached_target
);

    `MPPP_ASSERT_HOLD(a_out_hold, aclk, aresetn, m_valid, m_ready, m_speed, "stalled word changed speed")
    `MPPP_ASSERT(a_speed_range, aclk, aresetn, m_valid |-> ($signed(m_speed) <= 8'sd100) && ($signed(m_speed) >= -8'sd100), "speed out of range")
    `MPPP_ASSERT(a_zero_duty, aclk, aresetn, m_valid && (m_speed == 8'd0) |-> (m_drive_duty == 12'd0), "duty nonzero at zero speed")
    `MPPP_ASSERT(a_reached_stop, aclk, aresetn, m_valid && m_reached_target |-> (m_speed == 8'd0), "target reached with drive")
    `MPPP_ASSERT(a_pin_pair, aclk, aresetn, m_valid |-> (m_drive_pin != m_idle_pin), "drive and idle pin equal")

endmodule

bind multichannel_position_pid_pwm_top mppp_checker u_mppp_checker (.*);

`default_nettype wire
